[rtl/core/cvxh_pkg.sv]
package cvxh_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DET_W   = PROD_W + 1;
    localparam int DIST_W  = PROD_W + 1;
    localparam int ACC_W   = 57;
    localparam int AREA_W  = 55;
    localparam int MIN_HULL_POINTS = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_point;

endpackage

[rtl/core/convex_hull_with_area_core.sv]
// Channel   Direction  tdata (low bit up)                    tuser (low bit up)         tlast
// s_axis    in         point_x[23:0], point_y[23:0]          -                          set_last
// m_axis    out        hull_x[23:0], hull_y[23:0],           empty_hull, points_dropped result_last
//                      hull_area[54:0], one zero pad bit
//
// Points load one word per cycle, while the core is in S_LOAD, into a single-port point memory.
// The start search reads each stored point once, through the states S_MRD and S_MCMP.
// Each hull step scans the stored points other than the current vertex and candidate
// through the one read port and the one shared 25x25 multiplier, in S_CRD to S_CDEC per
// point, plus per vertex the first candidate, the step check, the two area products and the emit.
// Reset is synchronous and active low and clears the control state.
// A result waits in the output register; the walk stalls only when a new word is due.
module convex_hull_with_area_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,   // point_x, point_y
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,   // hull_x, hull_y, hull_area, zero pad
    output logic [1:0]   o_m_axis_tuser,   // empty_hull, points_dropped
    output logic         o_m_axis_tlast
);
    import cvxh_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_EMPTY, S_MRD, S_MCMP, S_ITER, S_CRD, S_CDIF, S_CD1, S_CD2,
        S_CQ1, S_CQ2, S_CDEC, S_STEP, S_A1, S_A2, S_EMITV
    } t_state;

    t_state r_state;
    logic   r_fin, r_emitl;

    t_point mem [0:MAX_POINTS-1];
    t_point r_rdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] r_cnt, r_i, r_n, n_cnt;
    logic          r_ovf, r_init;
    logic [AW-1:0] r_start, r_cur, r_nxt;
    t_coord r_sx, r_sy, r_cx, r_cy, r_nx, r_ny;
    t_diff  r_kdx, r_kdy, r_ndx, r_ndy, r_ax, r_ay, r_bx, r_by;
    t_prod  r_p;
    logic signed [DET_W-1:0] r_d;
    logic [DIST_W-1:0] r_dk, r_dn;
    logic signed [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] mag;

    t_diff mul_a, mul_b;
    t_prod prod;

    logic r_ovalid, r_oempty, r_odrop, r_olast;
    t_coord r_ox, r_oy;
    logic [AREA_W-1:0] r_oarea;

    logic accept_in, out_free, skip, emit_word;
    t_point in_pt;

    assign in_pt     = i_s_axis_tdata;
    assign accept_in = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_ovalid || i_m_axis_tready;
    assign n_cnt     = (r_cnt < CW'(MAX_POINTS)) ? r_cnt + CW'(1) : r_cnt;
    assign skip      = !r_init && (r_i[AW-1:0] == r_cur || r_i[AW-1:0] == r_nxt);
    assign mag       = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign emit_word = out_free && !r_fin
                       && (r_emitl || r_state == S_EMPTY || r_state == S_EMITV);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_i[AW-1:0];
        if (r_state == S_MRD && r_i < r_cnt) begin
            rd_en = 1'b1;
        end
        if (r_state == S_CRD && r_i < r_cnt && !skip) begin
            rd_en = 1'b1;
        end
    end

    always_comb begin
        case (r_state)
            S_CD1: begin
                mul_a = r_kdy;
                mul_b = r_ndx;
            end
            S_CD2: begin
                mul_a = r_ndy;
                mul_b = r_kdx;
            end
            S_CQ1: begin
                mul_a = r_kdx;
                mul_b = r_kdx;
            end
            S_CQ2: begin
                mul_a = r_kdy;
                mul_b = r_kdy;
            end
            S_A1: begin
                mul_a = r_ax;
                mul_b = r_by;
            end
            S_A2: begin
                mul_a = r_ay;
                mul_b = r_bx;
            end
            default: begin
                mul_a = r_kdx;
                mul_b = r_kdy;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (accept_in && r_cnt < CW'(MAX_POINTS)) begin
            mem[r_cnt[AW-1:0]] <= in_pt;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_fin    <= 1'b0;
            r_emitl  <= 1'b0;
            r_init   <= 1'b0;
            r_i      <= '0;
            r_n      <= '0;
            r_start  <= '0;
            r_cur    <= '0;
            r_nxt    <= '0;
            r_acc    <= '0;
        end else begin
            if (emit_word) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_fin) begin
                r_fin   <= 1'b0;
                r_emitl <= 1'b1;
            end else if (r_emitl) begin
                if (out_free) begin
                    r_emitl  <= 1'b0;
                    r_ox     <= r_cx;
                    r_oy     <= r_cy;
                    if (mag[ACC_W-1:1] > (ACC_W-1)'({AREA_W{1'b1}})) begin
                        r_oarea <= '1;
                    end else begin
                        r_oarea <= mag[AREA_W:1];
                    end
                    r_oempty <= 1'b0;
                    r_odrop  <= r_ovf;
                    r_olast  <= 1'b1;
                    r_cnt    <= '0;
                    r_ovf    <= 1'b0;
                    r_state  <= S_LOAD;
                end
            end else begin
                case (r_state)
                    S_LOAD: begin
                        if (accept_in) begin
                            r_cnt <= n_cnt;
                            if (r_cnt == CW'(MAX_POINTS)) begin
                                r_ovf <= 1'b1;
                            end
                            if (i_s_axis_tlast) begin
                                r_i <= '0;
                                r_state <= (n_cnt < CW'(MIN_HULL_POINTS)) ? S_EMPTY : S_MRD;
                            end
                        end
                    end
                    S_EMPTY: begin
                        if (out_free) begin
                            r_ox     <= '0;
                            r_oy     <= '0;
                            r_oarea  <= '0;
                            r_oempty <= 1'b1;
                            r_odrop  <= r_ovf;
                            r_olast  <= 1'b1;
                            r_cnt    <= '0;
                            r_ovf    <= 1'b0;
                            r_state  <= S_LOAD;
                        end
                    end
                    S_MRD: begin
                        if (r_i == r_cnt) begin
                            r_cur   <= r_start;
                            r_cx    <= r_sx;
                            r_cy    <= r_sy;
                            r_n     <= CW'(1);
                            r_acc   <= '0;
                            r_state <= S_ITER;
                        end else begin
                            r_state <= S_MCMP;
                        end
                    end
                    S_MCMP: begin
                        if (r_i == '0 || r_rdata.x < r_sx) begin
                            r_start <= r_i[AW-1:0];
                            r_sx    <= r_rdata.x;
                            r_sy    <= r_rdata.y;
                        end
                        r_i     <= r_i + CW'(1);
                        r_state <= S_MRD;
                    end
                    S_ITER: begin
                        r_nxt   <= (r_cur == '0) ? AW'(1) : '0;
                        r_i     <= (r_cur == '0) ? CW'(1) : '0;
                        r_init  <= 1'b1;
                        r_state <= S_CRD;
                    end
                    S_CRD: begin
                        if (r_i == r_cnt) begin
                            r_state <= S_STEP;
                        end else if (skip) begin
                            r_i <= r_i + CW'(1);
                        end else begin
                            r_state <= S_CDIF;
                        end
                    end
                    S_CDIF: begin
                        r_kdx   <= DIFF_W'(r_rdata.x) - DIFF_W'(r_cx);
                        r_kdy   <= DIFF_W'(r_rdata.y) - DIFF_W'(r_cy);
                        r_state <= r_init ? S_CQ1 : S_CD1;
                    end
                    S_CD1: begin
                        r_p     <= prod;
                        r_state <= S_CD2;
                    end
                    S_CD2: begin
                        r_d     <= DET_W'(r_p) - DET_W'(prod);
                        r_state <= S_CQ1;
                    end
                    S_CQ1: begin
                        if (!r_init && r_d[DET_W-1]) begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_CRD;
                        end else begin
                            r_p     <= prod;
                            r_state <= S_CQ2;
                        end
                    end
                    S_CQ2: begin
                        r_dk    <= DIST_W'($unsigned(r_p)) + DIST_W'($unsigned(prod));
                        r_state <= S_CDEC;
                    end
                    S_CDEC: begin
                        if (r_init || (!r_d[DET_W-1] && r_d != '0) || r_dk > r_dn) begin
                            r_nxt <= r_i[AW-1:0];
                            r_nx  <= r_rdata.x;
                            r_ny  <= r_rdata.y;
                            r_ndx <= r_kdx;
                            r_ndy <= r_kdy;
                            r_dn  <= r_dk;
                        end
                        r_i     <= r_init ? '0 : r_i + CW'(1);
                        r_init  <= 1'b0;
                        r_state <= S_CRD;
                    end
                    S_STEP: begin
                        if (r_nxt == r_start) begin
                            r_fin <= 1'b1;
                        end else begin
                            r_ax    <= DIFF_W'(r_cx) - DIFF_W'(r_sx);
                            r_ay    <= DIFF_W'(r_cy) - DIFF_W'(r_sy);
                            r_bx    <= DIFF_W'(r_nx) - DIFF_W'(r_sx);
                            r_by    <= DIFF_W'(r_ny) - DIFF_W'(r_sy);
                            r_state <= (r_n >= CW'(2)) ? S_A1 : S_EMITV;
                        end
                    end
                    S_A1: begin
                        r_acc   <= r_acc + ACC_W'(prod);
                        r_state <= S_A2;
                    end
                    S_A2: begin
                        r_acc   <= r_acc - ACC_W'(prod);
                        r_state <= S_EMITV;
                    end
                    S_EMITV: begin
                        if (out_free) begin
                            r_ox     <= r_cx;
                            r_oy     <= r_cy;
                            r_oarea  <= '0;
                            r_oempty <= 1'b0;
                            r_odrop  <= r_ovf;
                            r_olast  <= 1'b0;
                            r_cur    <= r_nxt;
                            r_cx     <= r_nx;
                            r_cy     <= r_ny;
                            r_n      <= r_n + CW'(1);
                            if (r_n + CW'(1) < r_cnt) begin
                                r_state <= S_ITER;
                            end else begin
                                r_fin <= 1'b1;
                            end
                        end
                    end
                    default: begin
                        r_state <= S_LOAD;
                    end
                endcase
            end
        end
    end

    assign o_s_axis_tready = (r_state == S_LOAD) && !r_fin && !r_emitl;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_oarea, r_oy, r_ox};
    assign o_m_axis_tuser  = {r_odrop, r_oempty};
    assign o_m_axis_tlast  = r_olast;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast)
        else $error("empty result without last flag");

    a_area_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tdata[102:48] == '0)
        else $error("area on a vertex that is not last");

    a_hull_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD && r_state != S_EMPTY && r_state != S_MRD && r_state != S_MCMP
        |-> r_n <= r_cnt && r_cnt <= CW'(MAX_POINTS))
        else $error("hull count beyond stored points");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    import cvxh_pkg::*;

    localparam int CAPACITY  = 64;
    localparam int RAND_GOAL = 32;
    localparam longint AREA_SAT = (64'd1 << AREA_W) - 1;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [AREA_W-1:0]         area;
        bit                        empty;
        bit                        dropped;
        bit                        last;
    } t_vertex;

    typedef struct {
        int x;
        int y;
        bit last;
        bit empty_set;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [47:0]  s_data = '0;
    logic         s_last = 1'b0;
    logic         m_ready = 1'b0;
    logic         s_ready;
    logic         m_valid;
    logic [103:0] m_data;
    logic [1:0]   m_user;
    logic         m_last;

    t_vertex hull_queue[$];
    longint  pts_x[CAPACITY];
    longint  pts_y[CAPACITY];
    int      stored_count = 0;
    bit      overflowed = 0;

    int errors = 0;
    int words_out = 0;
    int sets_done = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 76;
    bit hold_request = 0;

    convex_hull_with_area_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint dist2(int a, int b);
        longint dx;
        longint dy;
        dx = pts_x[b] - pts_x[a];
        dy = pts_y[b] - pts_y[a];
        return dx * dx + dy * dy;
    endfunction

    // Stores the point while there is room and, on the last one, wraps the set and returns its vertices.
    function automatic void wrap_hull(input int x, input int y, input bit last,
                                      output t_vertex verts[$]);
        int     hull[$];
        int     first;
        int     cur;
        int     nxt;
        longint d;
        longint acc;
        longint ax;
        longint ay;
        longint bx;
        longint by;
        t_vertex v;
        verts = {};
        if (stored_count < CAPACITY) begin
            pts_x[stored_count] = x;
            pts_y[stored_count] = y;
            stored_count++;
        end else begin
            overflowed = 1;
        end
        if (!last) return;
        v = '{x: '0, y: '0, area: '0, empty: 1, dropped: overflowed, last: 1};
        if (stored_count < MIN_HULL_POINTS) begin
            verts.push_back(v);
        end else begin
            first = 0;
            for (int i = 1; i < stored_count; i++)
                if (pts_x[i] < pts_x[first]) first = i;
            hull.push_back(first);
            cur = first;
            while (hull.size() < stored_count) begin
                nxt = (cur == 0) ? 1 : 0;
                for (int i = 0; i < stored_count; i++) begin
                    if (i == cur || i == nxt) continue;
                    d = (pts_y[i] - pts_y[cur]) * (pts_x[nxt] - pts_x[cur]) -
                        (pts_y[nxt] - pts_y[cur]) * (pts_x[i] - pts_x[cur]);
                    if (d < 0) continue;
                    if (d > 0 || dist2(cur, i) > dist2(cur, nxt)) nxt = i;
                end
                if (nxt == first) break;
                cur = nxt;
                hull.push_back(nxt);
            end
            acc = 0;
            for (int i = 1; i + 1 < hull.size(); i++) begin
                ax = pts_x[hull[i]] - pts_x[hull[0]];
                ay = pts_y[hull[i]] - pts_y[hull[0]];
                bx = pts_x[hull[i+1]] - pts_x[hull[0]];
                by = pts_y[hull[i+1]] - pts_y[hull[0]];
                acc += ax * by - ay * bx;
            end
            if (acc < 0) acc = -acc;
            acc = acc >>> 1;
            if (acc > AREA_SAT) acc = AREA_SAT;
            foreach (hull[k]) begin
                v.x = pts_x[hull[k]][COORD_W-1:0];
                v.y = pts_y[hull[k]][COORD_W-1:0];
                v.empty = 0;
                v.last = (k == hull.size() - 1);
                v.area = v.last ? acc[AREA_W-1:0] : '0;
                verts.push_back(v);
            end
        end
        stored_count = 0;
        overflowed = 0;
    endfunction

    task automatic send_point(input int x, input int y, input bit last, input bit empty_set);
        t_vertex verts[$];
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {y[23:0], x[23:0]};
        s_last <= last;
        do @(posedge i_clk); while (!s_ready);
        wrap_hull(x, y, last, verts);
        if (empty_set)
            hull_queue.push_back('{x: '0, y: '0, area: '0, empty: 1, dropped: 0, last: 1});
        else
            foreach (verts[k]) hull_queue.push_back(verts[k]);
        if (last) sets_done++;
        @(negedge i_clk);
    endtask

    task automatic send_set(input int size, input int mode);
        int x;
        int y;
        int base;
        base = $urandom_range(0, 8000) - 4000;
        for (int i = 0; i < size; i++) begin
            case (mode)
                0: begin
                    x = $urandom_range(0, 24'hFFFFFF) - 24'h800000;
                    y = $urandom_range(0, 24'hFFFFFF) - 24'h800000;
                end
                1: begin
                    x = $urandom_range(0, 8) - 4;
                    y = $urandom_range(0, 8) - 4;
                end
                default: begin
                    x = base + 3 * $urandom_range(0, 20);
                    y = 2 * x + 7;
                end
            endcase
            send_point(x, y, i == size - 1, 0);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            m_ready <= 1'b0;
            repeat (400) @(negedge i_clk);
            hold_request <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && m_valid && m_ready) begin
            words_out++;
            if (hull_queue.size() == 0) begin
                $error("unexpected word x=%0d y=%0d", $signed(m_data[23:0]),
                       $signed(m_data[47:24]));
                errors++;
            end else begin
                e = hull_queue.pop_front();
                if (m_data[23:0] !== e.x) begin
                    $error("hull_x expected %0d got %0d", e.x, $signed(m_data[23:0]));
                    errors++;
                end
                if (m_data[47:24] !== e.y) begin
                    $error("hull_y expected %0d got %0d", e.y, $signed(m_data[47:24]));
                    errors++;
                end
                if (m_data[102:48] !== e.area) begin
                    $error("hull_area expected %0d got %0d", e.area, m_data[102:48]);
                    errors++;
                end
                if (m_user[0] !== e.empty) begin
                    $error("empty_hull expected %0d got %0d", e.empty, m_user[0]);
                    errors++;
                end
                if (m_user[1] !== e.dropped) begin
                    $error("points_dropped expected %0d got %0d", e.dropped, m_user[1]);
                    errors++;
                end
                if (m_last !== e.last) begin
                    $error("result_last expected %0d got %0d", e.last, m_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_row rows[$];
        int   rand_items;
        int   set_size;
        rows = '{
            '{0, 0, 1, 1},
            '{8388607, 8388607, 0, 0}, '{-8388608, -8388608, 1, 1},
            '{-8388608, -8388608, 0, 0}, '{8388607, -8388608, 0, 0},
            '{0, 8388607, 1, 0},
            '{0, 0, 0, 0}, '{4096, 0, 0, 0}, '{4096, 4096, 0, 0}, '{0, 4096, 0, 0},
            '{2048, 2048, 0, 0}, '{2048, 0, 0, 0}, '{0, 2048, 1, 0},
            '{0, 0, 0, 0}, '{100, 100, 0, 0}, '{200, 200, 1, 0},
            '{5, 5, 0, 0}, '{5, 5, 0, 0}, '{5, 5, 1, 0},
            '{-7, 3, 0, 0}, '{9, -2, 0, 0}, '{-7, 3, 0, 0}, '{1, 8, 1, 0}
        };
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (rows[r]) send_point(rows[r].x, rows[r].y, rows[r].last, rows[r].empty_set);
        s_valid <= 1'b0;
        wait (hull_queue.size() == 0);
        @(negedge i_clk);
        send_set(65, 0);
        rand_items = 0;
        while (rand_items < RAND_GOAL) begin
            if (rand_items >= RAND_GOAL / 3 && send_idle_pct == 9) begin
                send_idle_pct = 76;
                recv_idle_pct = 9;
                send_set(6, 1);
            end
            if (rand_items >= 2 * RAND_GOAL / 3 && send_idle_pct != 0) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request = 1;
            end
            case ($urandom_range(0, 7))
                0: begin
                    set_size = $urandom_range(1, 2);
                    send_set(set_size, 0);
                    rand_items += set_size;
                end
                1: begin
                    send_set(6, 1);
                    rand_items += 6;
                end
                2: begin
                    send_set(5, 2);
                    rand_items += 5;
                end
                default: begin
                    set_size = $urandom_range(3, 10);
                    send_set(set_size, 0);
                    rand_items += set_size;
                end
            endcase
        end
        s_valid <= 1'b0;
        wait (hull_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d point sets, checked %0d hull words, including overflow,",
                 sets_done, words_out);
        $display("degenerate, collinear and coincident sets under back-pressure.");
        if (errors == 0 && hull_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
